@@ design/sphere_pair_distance_stats_core_assert.svh @@
// Assertion macros shared by the sphere pair distance statistics design.
`ifndef SPHERE_PAIR_DISTANCE_STATS_CORE_ASSERT_SVH
`define SPHERE_PAIR_DISTANCE_STATS_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define SPDS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define SPDS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/spds_pkg.sv @@
// Shared widths, defaults and types for the sphere pair distance statistics block.
package spds_pkg;

	localparam int FRAC_BITS_DEF     = 16;
	localparam int COORD_BITS_DEF    = 32;

	localparam int PORT_COORD_W      = 32;
	localparam int RADIUS_W          = 31;
	localparam int RSUM_W            = 32;
	localparam int DIST_W            = 33;
	localparam int MAX_W             = 34;
	localparam int MIN_OUT_W         = 30;
	localparam int SUM_W             = 64;
	localparam int HITS_W            = 32;

	// The minimum restarts at 10000.0; the whole part needs 14 bits.
	localparam int MIN_RESET_WHOLE   = 10000;
	localparam int MIN_RESET_WHOLE_W = 14;

	typedef struct packed {
		logic en;
		logic clear;
		logic hit;
	} stat_upd_t;

endpackage

@@ design/spds_sqrt.sv @@
// Iterative floor square root, two radicand bits per cycle.
module spds_sqrt #(
	parameter int ROOT_W = spds_pkg::DIST_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2*ROOT_W-1:0]   radicand,
	output logic                  busy,
	output logic                  done,
	output logic [ROOT_W-1:0]     root
);

	localparam int RAD_W = 2 * ROOT_W;
	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W:0]   rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [ROOT_W+2:0] rem_sh;
	logic [ROOT_W+2:0] trial;
	logic [ROOT_W+2:0] diff;
	logic              fits;

	// Bring down the next bit pair and try the next root bit.
	always_comb begin
		rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
		trial  = {1'b0, root_q, 2'b01};
		fits   = rem_sh >= trial;
		diff   = rem_sh - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (fits) begin
				rem_q  <= diff[ROOT_W:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[ROOT_W:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign root = root_q;

endmodule

@@ design/spds_stats.sv @@
// Running maximum, minimum, saturating sum and saturating collision count.
module spds_stats #(
	parameter int FRAC_BITS = spds_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  spds_pkg::stat_upd_t                   upd,
	input  logic [spds_pkg::DIST_W-1:0]           dist_val,
	output logic signed [spds_pkg::MAX_W-1:0]     max_dist,
	output logic [spds_pkg::MIN_OUT_W-1:0]        min_dist,
	output logic [spds_pkg::SUM_W-1:0]            sum_dist,
	output logic [spds_pkg::HITS_W-1:0]           hits
);

	localparam int MW    = spds_pkg::MAX_W;
	localparam int DW    = spds_pkg::DIST_W;
	localparam int SW    = spds_pkg::SUM_W;
	localparam int HW    = spds_pkg::HITS_W;
	localparam int MIN_W = (FRAC_BITS + spds_pkg::MIN_RESET_WHOLE_W > DW) ?
		FRAC_BITS + spds_pkg::MIN_RESET_WHOLE_W : DW;

	localparam logic signed [MW-1:0] MAX_RST = MW'(-(longint'(1) << FRAC_BITS));
	localparam logic [MIN_W-1:0] MIN_RST =
		MIN_W'(longint'(spds_pkg::MIN_RESET_WHOLE) << FRAC_BITS);

	logic signed [MW-1:0] max_q;
	logic [MIN_W-1:0]     min_q;
	logic [SW-1:0]        sum_q;
	logic [HW-1:0]        hits_q;

	logic signed [MW-1:0] base_max;
	logic [MIN_W-1:0]     base_min;
	logic [SW-1:0]        base_sum;
	logic [HW-1:0]        base_hits;
	logic signed [MW-1:0] dist_s;
	logic [SW:0]          sum_ext;

	// A clear restores the start values before this transaction is counted.
	always_comb begin
		base_max  = upd.clear ? MAX_RST : max_q;
		base_min  = upd.clear ? MIN_RST : min_q;
		base_sum  = upd.clear ? '0 : sum_q;
		base_hits = upd.clear ? '0 : hits_q;
		dist_s    = signed'(MW'(dist_val));
		sum_ext   = {1'b0, base_sum} + (SW + 1)'(dist_val);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q  <= MAX_RST;
			min_q  <= MIN_RST;
			sum_q  <= '0;
			hits_q <= '0;
		end else if (upd.en) begin
			max_q  <= (dist_s > base_max) ? dist_s : base_max;
			min_q  <= (MIN_W'(dist_val) < base_min) ? MIN_W'(dist_val) : base_min;
			sum_q  <= sum_ext[SW] ? '1 : sum_ext[SW-1:0];
			hits_q <= (upd.hit && (base_hits != '1)) ? base_hits + 1'b1 : base_hits;
		end
	end

	assign max_dist = max_q;
	assign min_dist = min_q[spds_pkg::MIN_OUT_W-1:0];
	assign sum_dist = sum_q;
	assign hits     = hits_q;

endmodule

@@ design/sphere_pair_distance_stats_core.sv @@
// Top level of the sphere pair distance statistics block: sequencer, squaring and output.
//
// Each input transaction carries two spheres (centres and radii in Q16.16) and a
// clear flag. The block squares the three centre differences on one multiplier,
// takes the floor square root of their sum on a single two-bit-per-cycle root
// unit, and then updates the running maximum, minimum, saturating distance sum
// and saturating collision count. One result transaction leaves for every input
// transaction; its statistics fields show the values after this pair was
// counted, with a clear applied before the pair. The block works on one pair at
// a time: after an accept it squares and sums the centre differences in the
// multiply-accumulate, runs the root unit and updates the statistics, and it
// takes the next pair only once back in idle. A finished result sits in an output
// register, so the next pair can be taken while it waits; only when a second
// result is ready before the first has been taken does the sequencer hold.
// Coordinates use their low COORD_BITS bits as a two's complement value.
module sphere_pair_distance_stats_core #(
	parameter int FRAC_BITS  = spds_pkg::FRAC_BITS_DEF,
	parameter int COORD_BITS = spds_pkg::COORD_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic signed [spds_pkg::PORT_COORD_W-1:0]  first_x,
	input  logic signed [spds_pkg::PORT_COORD_W-1:0]  first_y,
	input  logic signed [spds_pkg::PORT_COORD_W-1:0]  first_z,
	input  logic [spds_pkg::RADIUS_W-1:0]             first_radius,
	input  logic signed [spds_pkg::PORT_COORD_W-1:0]  second_x,
	input  logic signed [spds_pkg::PORT_COORD_W-1:0]  second_y,
	input  logic signed [spds_pkg::PORT_COORD_W-1:0]  second_z,
	input  logic [spds_pkg::RADIUS_W-1:0]             second_radius,
	input  logic                                      clear_stats,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic [spds_pkg::DIST_W-1:0]               pair_distance,
	output logic                                      collided,
	output logic signed [spds_pkg::MAX_W-1:0]         largest_distance,
	output logic [spds_pkg::MIN_OUT_W-1:0]            smallest_distance,
	output logic [spds_pkg::SUM_W-1:0]                distance_total,
	output logic [spds_pkg::HITS_W-1:0]               collision_total
);

	`include "sphere_pair_distance_stats_core_assert.svh"

	localparam int CB     = COORD_BITS;
	localparam int ROOT_W = CB + 1;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int DW     = spds_pkg::DIST_W;
	localparam int RSW    = spds_pkg::RSUM_W;

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_SQUARE    = 3'd1;
	localparam logic [2:0] ST_ROOT_GO   = 3'd2;
	localparam logic [2:0] ST_ROOT_WAIT = 3'd3;
	localparam logic [2:0] ST_UPDATE    = 3'd4;

	localparam logic [1:0] SQ_LAST = 2'd3;

	logic [2:0]          state_q;
	logic [2:0]          state_d;
	logic [1:0]          sq_cnt_q;
	logic [2:0][CB-1:0]  delta_q;
	logic [RSW-1:0]      rsum_q;
	logic                clear_q;
	logic [2*CB-1:0]     prod_q;
	logic [RAD_W-1:0]    acc_q;
	logic                out_valid_q;
	logic [DW-1:0]       pair_distance_q;
	logic                collided_q;

	logic [2:0][CB-1:0]  delta_d;
	logic [2:0][CB:0]    coord_a;
	logic [2:0][CB:0]    coord_b;
	logic [2:0][CB:0]    coord_diff;
	logic [CB-1:0]       mul_sel;
	logic                in_xfer;
	logic                root_start;
	logic                root_busy;
	logic                root_done;
	logic [ROOT_W-1:0]   root;
	logic [DW-1:0]       dist_val;
	logic                hit;
	logic                out_free;
	spds_pkg::stat_upd_t upd;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Sign-extend the low COORD_BITS of each coordinate by one bit, then take
	// the magnitude of the difference; it always fits in COORD_BITS bits.
	always_comb begin
		coord_a[0] = {first_x[CB-1], first_x[CB-1:0]};
		coord_a[1] = {first_y[CB-1], first_y[CB-1:0]};
		coord_a[2] = {first_z[CB-1], first_z[CB-1:0]};
		coord_b[0] = {second_x[CB-1], second_x[CB-1:0]};
		coord_b[1] = {second_y[CB-1], second_y[CB-1:0]};
		coord_b[2] = {second_z[CB-1], second_z[CB-1:0]};
		for (int k = 0; k < 3; k++) begin
			coord_diff[k] = coord_a[k] - coord_b[k];
			delta_d[k]    = coord_diff[k][CB] ? CB'(-coord_diff[k]) : coord_diff[k][CB-1:0];
		end
	end

	// The multiplier walks the three deltas; its product is registered and
	// folded into the radicand on the next cycle.
	always_comb begin
		case (sq_cnt_q)
			2'd0:    mul_sel = delta_q[0];
			2'd1:    mul_sel = delta_q[1];
			default: mul_sel = delta_q[2];
		endcase
	end

	assign dist_val = DW'(root);
	assign hit      = {1'b0, rsum_q} >= dist_val;

	always_comb begin
		state_d    = state_q;
		root_start = 1'b0;
		upd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SQUARE;
				end
			end
			ST_SQUARE: begin
				if (sq_cnt_q == SQ_LAST) begin
					state_d = ST_ROOT_GO;
				end
			end
			ST_ROOT_GO: begin
				root_start = 1'b1;
				state_d    = ST_ROOT_WAIT;
			end
			ST_ROOT_WAIT: begin
				if (root_done) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				// The statistics registers feed the output directly, so they
				// may only move once the previous result has gone.
				if (out_free) begin
					upd.en    = 1'b1;
					upd.clear = clear_q;
					upd.hit   = hit;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sq_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_xfer) begin
				sq_cnt_q <= '0;
			end else if (state_q == ST_SQUARE) begin
				sq_cnt_q <= sq_cnt_q + 1'b1;
			end
			if (upd.en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			delta_q <= delta_d;
			rsum_q  <= RSW'(first_radius) + RSW'(second_radius);
			clear_q <= clear_stats;
			acc_q   <= '0;
		end else if (state_q == ST_SQUARE) begin
			prod_q <= mul_sel * mul_sel;
			if (sq_cnt_q != 2'd0) begin
				acc_q <= acc_q + RAD_W'(prod_q);
			end
		end
		if (upd.en) begin
			pair_distance_q <= dist_val;
			collided_q      <= hit;
		end
	end

	spds_sqrt #(
		.ROOT_W (ROOT_W)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (acc_q),
		.busy     (root_busy),
		.done     (root_done),
		.root     (root)
	);

	spds_stats #(
		.FRAC_BITS (FRAC_BITS)
	) u_stats (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (upd),
		.dist_val (dist_val),
		.max_dist (largest_distance),
		.min_dist (smallest_distance),
		.sum_dist (distance_total),
		.hits     (collision_total)
	);

	assign out_valid     = out_valid_q;
	assign pair_distance = pair_distance_q;
	assign collided      = collided_q;

	`SPDS_ASSERT_IMP(a_idle_root_quiet, in_ready, !root_busy, "root unit busy while idle")
	`SPDS_ASSERT_IMP(a_done_in_wait, root_done, state_q == ST_ROOT_WAIT, "root done out of step")
	`SPDS_ASSERT_IMP(a_update_free, upd.en, out_free, "result register overwritten")
	`SPDS_ASSERT_NXT(a_accept_square, in_xfer, (state_q == ST_SQUARE) && (sq_cnt_q == 2'd0),
		"accept did not start squaring")

endmodule

@@ dv/sphere_pair_distance_stats_core_tb.sv @@
// Self-checking testbench for the sphere pair distance statistics core.
`timescale 1ns / 100ps

module sphere_pair_distance_stats_core_tb;

	localparam int PORT_COORD_W    = spds_pkg::PORT_COORD_W;
	localparam int RADIUS_W        = spds_pkg::RADIUS_W;
	localparam int RSUM_W          = spds_pkg::RSUM_W;
	localparam int DIST_W          = spds_pkg::DIST_W;
	localparam int MAX_W           = spds_pkg::MAX_W;
	localparam int MIN_OUT_W       = spds_pkg::MIN_OUT_W;
	localparam int SUM_W           = spds_pkg::SUM_W;
	localparam int HITS_W          = spds_pkg::HITS_W;
	localparam int FRAC_BITS_DEF   = spds_pkg::FRAC_BITS_DEF;
	localparam int MIN_RESET_WHOLE = spds_pkg::MIN_RESET_WHOLE;

	localparam int CLK_PERIOD  = 10;
	localparam int TOTAL_PAIRS = 1500;
	localparam int RADICAND_W  = 2 * DIST_W;
	// The output side is held off for this long once, with the input side at full rate.
	localparam int HOLD_CYCLES = 600;
	// Longest stretch without any transaction on either side before the run is abandoned.
	localparam int QUIET_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 60;

	localparam logic signed [PORT_COORD_W-1:0] MOST_NEG = 32'sh8000_0000;
	localparam logic signed [PORT_COORD_W-1:0] MOST_POS = 32'sh7fff_ffff;
	localparam logic signed [PORT_COORD_W-1:0] ONE      = 32'sd1 <<< FRAC_BITS_DEF;
	localparam logic [RADIUS_W-1:0]            RAD_MAX  = '1;

	// Statistics restart values: -1.0 for the maximum, 10000.0 for the minimum.
	localparam logic signed [MAX_W-1:0] PEAK_RESET  = -(34'sd1 <<< FRAC_BITS_DEF);
	localparam logic [MIN_OUT_W-1:0]    FLOOR_RESET = MIN_OUT_W'(MIN_RESET_WHOLE << FRAC_BITS_DEF);

	// One input transaction: two spheres and the clear flag.
	typedef struct {
		logic signed [PORT_COORD_W-1:0] ax, ay, az;
		logic [RADIUS_W-1:0]            ar;
		logic signed [PORT_COORD_W-1:0] bx, by, bz;
		logic [RADIUS_W-1:0]            br;
		logic                           clr;
	} pair_t;

	// One output transaction: the distance of the pair and the statistics after it.
	typedef struct {
		logic [DIST_W-1:0]        dist_val;
		logic                     hit;
		logic signed [MAX_W-1:0]  maxd;
		logic [MIN_OUT_W-1:0]     mind;
		logic [SUM_W-1:0]         total;
		logic [HITS_W-1:0]        hits;
	} stats_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic  in_valid  = 1'b0;
	logic  out_ready = 1'b0;
	logic  in_ready;
	logic  out_valid;
	pair_t offer     = '{default: '0};

	logic [DIST_W-1:0]       pair_distance;
	logic                    collided;
	logic signed [MAX_W-1:0] largest_distance;
	logic [MIN_OUT_W-1:0]    smallest_distance;
	logic [SUM_W-1:0]        distance_total;
	logic [HITS_W-1:0]       collision_total;

	// Pairs waiting to be offered, and the statistics expected back, oldest first.
	pair_t  pending_pairs[$];
	stats_t expected_stats[$];

	// Our own copy of the accumulators, advanced once per accepted pair.
	logic signed [MAX_W-1:0] peak_dist = PEAK_RESET;
	logic [MIN_OUT_W-1:0]    low_dist  = FLOOR_RESET;
	logic [SUM_W-1:0]        dist_sum  = '0;
	logic [HITS_W-1:0]       hit_count = '0;

	int n_pairs_in   = 0;
	int n_collisions = 0;
	int n_clears     = 0;
	int n_errors     = 0;
	int total_pairs  = 0;
	int hold_at      = 0;
	int hold_left    = 0;
	bit hold_fired   = 1'b0;
	int quiet_cycles = 0;

	sphere_pair_distance_stats_core uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.first_x           (offer.ax),
		.first_y           (offer.ay),
		.first_z           (offer.az),
		.first_radius      (offer.ar),
		.second_x          (offer.bx),
		.second_y          (offer.by),
		.second_z          (offer.bz),
		.second_radius     (offer.br),
		.clear_stats       (offer.clr),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.pair_distance     (pair_distance),
		.collided          (collided),
		.largest_distance  (largest_distance),
		.smallest_distance (smallest_distance),
		.distance_total    (distance_total),
		.collision_total   (collision_total)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Absolute difference of two coordinates; it reaches 2^32 - 1 at the extremes.
	function automatic logic [DIST_W-1:0] axis_span(logic signed [PORT_COORD_W-1:0] a,
			logic signed [PORT_COORD_W-1:0] b);
		logic signed [DIST_W:0] d;
		d = {{2{a[PORT_COORD_W-1]}}, a} - {{2{b[PORT_COORD_W-1]}}, b};
		return d[DIST_W] ? DIST_W'(-d) : DIST_W'(d);
	endfunction

	// Floor square root, one result bit per pass from the top down.
	function automatic logic [DIST_W-1:0] floor_root(logic [RADICAND_W-1:0] radicand);
		logic [DIST_W-1:0] root;
		logic [DIST_W-1:0] trial;
		root = '0;
		for (int b = DIST_W - 1; b >= 0; b--) begin
			trial = root | (DIST_W'(1) << b);
			if ({{DIST_W{1'b0}}, trial} * {{DIST_W{1'b0}}, trial} <= radicand)
				root = trial;
		end
		return root;
	endfunction

	// Distance and collision of one pair, then the accumulator update. A clear
	// restores the accumulators before this pair is counted. The collision test
	// compares the radius sum with the floored distance, not the exact one.
	function automatic stats_t account_pair(pair_t p);
		stats_t r;
		logic [DIST_W-1:0]     dx, dy, dz;
		logic [RADICAND_W-1:0] radicand;
		logic [RSUM_W-1:0]     reach;
		logic [SUM_W:0]        wide;
		dx = axis_span(p.ax, p.bx);
		dy = axis_span(p.ay, p.by);
		dz = axis_span(p.az, p.bz);
		radicand = {{DIST_W{1'b0}}, dx} * {{DIST_W{1'b0}}, dx}
			+ {{DIST_W{1'b0}}, dy} * {{DIST_W{1'b0}}, dy}
			+ {{DIST_W{1'b0}}, dz} * {{DIST_W{1'b0}}, dz};
		r.dist_val = floor_root(radicand);
		reach = RSUM_W'(p.ar) + RSUM_W'(p.br);
		r.hit = ({1'b0, reach} >= r.dist_val);
		if (p.clr) begin
			peak_dist = PEAK_RESET;
			low_dist  = FLOOR_RESET;
			dist_sum  = '0;
			hit_count = '0;
		end
		if ($signed({1'b0, r.dist_val}) > peak_dist)
			peak_dist = $signed({1'b0, r.dist_val});
		if (r.dist_val < {{(DIST_W - MIN_OUT_W){1'b0}}, low_dist})
			low_dist = MIN_OUT_W'(r.dist_val);
		// Both the sum and the collision count stick at all ones.
		wide = {1'b0, dist_sum} + {{(SUM_W + 1 - DIST_W){1'b0}}, r.dist_val};
		dist_sum = wide[SUM_W] ? '1 : wide[SUM_W-1:0];
		if (r.hit && hit_count != '1)
			hit_count = hit_count + 1'b1;
		r.maxd  = peak_dist;
		r.mind  = low_dist;
		r.total = dist_sum;
		r.hits  = hit_count;
		return r;
	endfunction

	function automatic logic signed [PORT_COORD_W-1:0] extreme_coord();
		case ($urandom_range(3))
			0: return MOST_NEG;
			1: return MOST_POS;
			2: return '0;
			default: return -1;
		endcase
	endfunction

	// Random pair. Half are close pairs or exact integer distances so that
	// collisions, boundary hits and new minimums happen often; the rest spread
	// over the whole coordinate range and its corners.
	function automatic pair_t random_pair();
		pair_t p;
		int    spread;
		int    k;
		p.ax  = $urandom;
		p.ay  = $urandom;
		p.az  = $urandom;
		p.bx  = $urandom;
		p.by  = $urandom;
		p.bz  = $urandom;
		p.ar  = RADIUS_W'($urandom);
		p.br  = RADIUS_W'($urandom);
		p.clr = ($urandom_range(39) == 0);
		case ($urandom_range(9))
			0, 1, 2: begin
				spread = 1 << $urandom_range(4, 24);
				p.bx = p.ax + PORT_COORD_W'(int'($urandom_range(0, spread)) - spread / 2);
				p.by = p.ay + PORT_COORD_W'(int'($urandom_range(0, spread)) - spread / 2);
				p.bz = p.az + PORT_COORD_W'(int'($urandom_range(0, spread)) - spread / 2);
				p.ar = RADIUS_W'($urandom_range(0, spread / 2));
				p.br = RADIUS_W'($urandom_range(0, spread / 2));
			end
			3, 4: begin
				// A 3-4-5 offset gives an exact distance of 5k; radii in steps of k.
				k = $urandom_range(0, 2000) << FRAC_BITS_DEF;
				p.bx = p.ax + PORT_COORD_W'(3 * k);
				p.by = p.ay + PORT_COORD_W'(4 * k);
				p.bz = p.az;
				p.ar = RADIUS_W'(k * $urandom_range(0, 5));
				p.br = RADIUS_W'(k * $urandom_range(0, 5));
			end
			5: begin
				p.ax = extreme_coord();
				p.ay = extreme_coord();
				p.az = extreme_coord();
				p.bx = extreme_coord();
				p.by = extreme_coord();
				p.bz = extreme_coord();
				p.ar = $urandom_range(1) ? RAD_MAX : '0;
				p.br = $urandom_range(1) ? RAD_MAX : '0;
			end
			6: begin
				p.bx = p.ax;
				p.by = p.ay;
				p.bz = p.az;
			end
			7: begin
				p.ar = RAD_MAX;
				p.br = RAD_MAX;
			end
			default: begin
			end
		endcase
		return p;
	endfunction

	task automatic queue_pair(logic signed [PORT_COORD_W-1:0] ax, logic signed [PORT_COORD_W-1:0] ay,
			logic signed [PORT_COORD_W-1:0] az, logic [RADIUS_W-1:0] ar,
			logic signed [PORT_COORD_W-1:0] bx, logic signed [PORT_COORD_W-1:0] by,
			logic signed [PORT_COORD_W-1:0] bz, logic [RADIUS_W-1:0] br, logic clr);
		pending_pairs.push_back('{ax, ay, az, ar, bx, by, bz, br, clr});
	endtask

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			n_errors++;
		end
	endtask

	// Idle share in percent for each side. The first third of the pairs runs a
	// mostly idle receiver, the second third a mostly idle sender, and the rest
	// runs at full rate. A quarter of every 128 pairs has no idling at all.
	function automatic int idle_share(bit sender_side);
		if ((n_pairs_in % 128) >= 96)
			return 0;
		if (n_pairs_in < total_pairs / 3)
			return sender_side ? 6 : 82;
		if (n_pairs_in < 2 * total_pairs / 3)
			return sender_side ? 82 : 6;
		return 0;
	endfunction

	// Driver: when the current pair is taken, its expected statistics are worked
	// out at that very edge, so predictions follow the order of acceptance. A new
	// pair is put up only once the slot is free; an offered pair stays put.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_stats.push_back(account_pair(offer));
				n_pairs_in <= n_pairs_in + 1;
				if (offer.clr)
					n_clears <= n_clears + 1;
			end
			if (!in_valid || in_ready) begin
				if (pending_pairs.size() != 0 && $urandom_range(99) >= idle_share(1'b1)) begin
					offer    <= pending_pairs.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: every result transaction is matched against the oldest
	// expectation. Once, in the full-rate part, the receiver stops for a long
	// stretch so that the block's output register and then its input side fill.
	always @(posedge clk or negedge arst_n) begin : result_check
		stats_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_stats.size() == 0) begin
					$error("result transaction with no pair outstanding");
					n_errors++;
				end else begin
					want = expected_stats.pop_front();
					check_field("pair_distance", 64'(want.dist_val), 64'(pair_distance));
					check_field("collided", 64'(want.hit), 64'(collided));
					check_field("largest_distance", 64'(want.maxd), 64'(largest_distance));
					check_field("smallest_distance", 64'(want.mind), 64'(smallest_distance));
					check_field("distance_total", want.total, distance_total);
					check_field("collision_total", 64'(want.hits), 64'(collision_total));
					if (want.hit)
						n_collisions <= n_collisions + 1;
				end
			end
			if (!hold_fired && n_pairs_in >= hold_at) begin
				hold_fired = 1'b1;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left = hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= idle_share(1'b0));
			end
		end
	end

	// Watchdog: a run that goes quiet on both sides for too long has hung.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("sphere_pair_distance_stats_core_tb: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		// Directed pairs first: coincident centres, the coordinate corners,
		// single-axis extremes, collisions exactly at and just past the radius
		// sum, a floored distance that still collides, and clears, alone, in a
		// row and together with a pair.
		queue_pair(0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
		queue_pair(MOST_NEG, MOST_NEG, MOST_NEG, RAD_MAX, MOST_POS, MOST_POS, MOST_POS, RAD_MAX, 1'b0);
		queue_pair(MOST_POS, MOST_POS, MOST_POS, 0, MOST_NEG, MOST_NEG, MOST_NEG, 0, 1'b1);
		queue_pair(MOST_NEG, 0, 0, 0, MOST_POS, 0, 0, 0, 1'b0);
		queue_pair(0, 0, MOST_POS, RAD_MAX, 0, 0, MOST_NEG, 0, 1'b0);
		queue_pair(0, -1, 0, 0, 0, MOST_NEG, 0, 1, 1'b0);
		queue_pair(-1, -1, -1, 0, MOST_NEG, MOST_NEG, MOST_NEG, 0, 1'b0);
		// 3-4-5 triangle: distance exactly 5.0, radius sum 5.0 and one unit short.
		queue_pair(0, 0, 0, 2 * ONE, 3 * ONE, 4 * ONE, 0, 3 * ONE, 1'b1);
		queue_pair(0, 0, 0, 2 * ONE, 3 * ONE, 4 * ONE, 0, 3 * ONE - 1, 1'b0);
		// Exact distance is sqrt(2) units, floored to 1: a radius sum of 1 collides.
		queue_pair(1, 1, 0, 1, 0, 0, 0, 0, 1'b0);
		queue_pair(1, 1, 0, 0, 0, 0, 0, 0, 1'b0);
		queue_pair(-ONE, -ONE, -ONE, ONE, ONE, ONE, ONE, 0, 1'b1);
		queue_pair(-30000 * ONE, 0, 0, 0, 30000 * ONE, 0, 0, 0, 1'b0);
		// A distance of exactly 10000.0 right after a clear leaves the minimum as is.
		queue_pair(0, 0, 0, 0, 10000 * ONE, 0, 0, 0, 1'b1);
		queue_pair(0, 0, 0, 0, 9999 * ONE, 0, 0, 0, 1'b1);
		queue_pair(5, -7, 9, RAD_MAX, -5, 7, -9, RAD_MAX, 1'b1);
		queue_pair(ONE, 2 * ONE, -3 * ONE, ONE, ONE, 2 * ONE, -3 * ONE, ONE, 1'b0);
		queue_pair(32'sh5555_5555, 32'sh2aaa_aaaa, 32'sh7fff_0000, 31'h2aaa_aaaa,
			32'shaaaa_aaaa, 32'shd555_5555, 32'sh0000_ffff, 31'h5555_5555, 1'b0);
		repeat (TOTAL_PAIRS - pending_pairs.size())
			pending_pairs.push_back(random_pair());
		total_pairs = pending_pairs.size();
		hold_at     = 2 * total_pairs / 3 + 20;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_pairs.size() != 0 || in_valid || expected_stats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d sphere pairs, %0d of them colliding and %0d carrying a clear,",
			n_pairs_in, n_collisions, n_clears);
		$display("through sender-idle, receiver-idle and full-rate pacing plus one long output stall.");
		if (n_errors == 0)
			$display("sphere_pair_distance_stats_core_tb: clean");
		else
			$display("sphere_pair_distance_stats_core_tb: errors");
		$finish;
	end

endmodule
